// ===== rtl/pe_pkg.sv =====
// Package for the particle emitter: sizes, state encoding, memory word layout,
// the quarter-wave sine table and small arithmetic helpers.
// No dependencies.
package pe_pkg;

    localparam int MAX_POOL     = 64;
    localparam int IDX_W        = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CNT_W        = $clog2(MAX_POOL + 1);
    localparam int TRIG_ENTRIES = 256;
    localparam int TRIG_BITS    = $clog2(TRIG_ENTRIES);
    localparam int QTR_BITS     = TRIG_BITS - 2;
    localparam int TRIG_QTR     = TRIG_ENTRIES / 4;

    localparam int DIV_N        = 32;
    localparam int DIV_D        = 24;
    localparam int DIV_STEP     = 4;
    localparam int DIV_CYC      = DIV_N / DIV_STEP;
    localparam int DIV_CNT_W    = $clog2(DIV_CYC);

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] LFSR_RESET = 16'hACE1;

    typedef enum logic [2:0] {
        CFG_MAX_PARTICLES = 3'd0,
        CFG_EMIT_RATE     = 3'd1,
        CFG_MAX_AGE       = 3'd2,
        CFG_ACCEL_XY      = 3'd3,
        CFG_DIRECTION     = 3'd4,
        CFG_POWER         = 3'd5,
        CFG_ALPHA         = 3'd6,
        CFG_RANDOM_SEED   = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DVX,
        ST_DVY,
        ST_EMIT,
        ST_ACC,
        ST_SP_A,
        ST_SP_B,
        ST_SP_C,
        ST_SP_D,
        ST_SP_E,
        ST_SP_F,
        ST_UP_RD,
        ST_UP_LD,
        ST_UP_MA,
        ST_UP_MX,
        ST_UP_MY,
        ST_UP_WB,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic [7:0]         alpha;
        logic [23:0]        age;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef logic [14:0] t_trig_tab [TRIG_QTR + 1];

    function automatic t_trig_tab build_trig();
        t_trig_tab tab;
        longint c1, c3, c5, c7, c9;
        longint u, v, w, t, s;
        c1 = 64'sd1686629713;
        c3 = 64'sd693598668;
        c5 = 64'sd85569306;
        c7 = 64'sd5026994;
        c9 = 64'sd172272;
        for (int ui = 0; ui <= TRIG_QTR; ui++) begin
            u = 4 * ui;
            v = (u <<< 30) / TRIG_ENTRIES;
            w = (v * v) >>> 30;
            t = c9;
            t = c7 - ((t * w) >>> 30);
            t = c5 - ((t * w) >>> 30);
            t = c3 - ((t * w) >>> 30);
            t = c1 - ((t * w) >>> 30);
            s = (t * v) >>> 30;
            s = (s + 32768) >>> 16;
            if (s > 16384) begin
                s = 16384;
            end
            tab[ui] = 15'(s);
        end
        return tab;
    endfunction

    localparam t_trig_tab TRIG_TAB = build_trig();

    // sine (cos_sel low) or cosine of idx/TRIG_ENTRIES turns, signed Q2.14
    function automatic logic signed [15:0] trig_val(logic [TRIG_BITS-1:0] idx,
                                                    logic cos_sel);
        logic [1:0]          q;
        logic [QTR_BITS-1:0] lo;
        logic [QTR_BITS:0]   ui;
        logic [15:0]         m;
        q  = idx[TRIG_BITS-1 -: 2] + {1'b0, cos_sel};
        lo = idx[QTR_BITS-1:0];
        ui = q[0] ? ((QTR_BITS + 1)'(TRIG_QTR) - {1'b0, lo}) : {1'b0, lo};
        m  = {1'b0, TRIG_TAB[ui]};
        return q[1] ? -m : m;
    endfunction

    function automatic logic [15:0] lfsr_next(logic [15:0] s);
        return (s >> 1) ^ (s[0] ? LFSR_TAPS : 16'h0000);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [33:0] x);
        if (x > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== rtl/pe_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/pe_div.sv =====
// Iterative unsigned divider, several quotient bits per cycle.
// Depends on pe_pkg.
module pe_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pe_pkg::DIV_N-1:0]  i_dividend,
    input  logic [pe_pkg::DIV_D-1:0]  i_divisor,
    output logic                      o_busy,
    output logic [pe_pkg::DIV_N-1:0]  o_quotient
);
    import pe_pkg::*;

    logic [DIV_D-1:0]     r_rem, n_rem;
    logic [DIV_N-1:0]     r_quo, n_quo;
    logic [DIV_D-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [DIV_D:0]       trial;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, n_quo[DIV_N-1]};
            n_quo = n_quo << 1;
            if (trial >= {1'b0, r_div}) begin
                n_rem    = DIV_D'(trial - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[DIV_D-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/particle_emitter_update.sv =====
// Particle emitter: spawn from the emission accumulator, then age, move and
// compact the pool in one state memory and stream out the survivors.
// Depends on pe_pkg, pe_ram and pe_div.
// The walk is set by the one memory port pair and the alpha divider. One tick at a time.
// Reset: synchronous, active low; clears pool count and accumulator, loads
// register defaults and the LFSR seed. Entry contents need no reset.
module particle_emitter_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic                        i_tick_valid,
    output logic                        o_tick_ready,
    input  logic [15:0]                 i_tick_time,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic signed [31:0]          o_pos_x,
    output logic signed [31:0]          o_pos_y,
    output logic [7:0]                  o_alpha,
    output logic                        o_slot_empty,
    output logic                        o_last_one,
    output logic [6:0]                  o_live_count
);
    import pe_pkg::*;

    t_state r_state, n_state;

    logic [6:0]  r_max_particles;
    logic [15:0] r_emit_rate;
    logic [15:0] r_max_age;
    logic [31:0] r_accel_xy;
    logic [31:0] r_direction;
    logic [31:0] r_power_setup;
    logic [15:0] r_alpha_setup;

    logic [15:0]       r_lfsr;
    logic [31:0]       r_acc;
    logic [CNT_W-1:0]  r_count, r_nspawn, r_i, r_keep, r_j;
    logic [15:0]       r_dt;
    logic signed [31:0] r_dvx, r_dvy;
    logic [15:0]       r_angle;
    logic signed [16:0] r_power;
    logic signed [15:0] r_sn, r_cs;
    logic signed [31:0] r_vx;

    logic [23:0]        r_age_n;
    logic signed [31:0] r_vx_n, r_vy_n, r_px, r_py;

    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] r_prod;

    logic signed [31:0] r_out_px, r_out_py;
    logic [7:0]         r_out_alpha;
    logic               r_out_empty, r_out_last;
    logic [6:0]         r_out_live;

    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    t_entry             mem_wdata, mem_rdata;

    logic               div_start, div_busy;
    logic [31:0]        div_quo;

    logic [15:0]        lfsr_n;
    logic signed [15:0] rnd;
    logic [6:0]         lim7;
    logic [CNT_W-1:0]   limit, room, nsp;
    logic [32:0]        sum33;
    logic [31:0]        sum32;
    logic [7:0]         whole;
    logic [7:0]         a0, a1, adiff;
    logic               aneg;
    logic [23:0]        life;
    logic [24:0]        age_sum;
    logic [8:0]         asum;
    logic [7:0]         alpha_v;
    logic               keep_it;

    pe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POOL)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    pe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[31:0]),
        .i_divisor  (life),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_comb begin
        lfsr_n = lfsr_next(r_lfsr);
        rnd    = {~lfsr_n[15], lfsr_n[14:0]};
        lim7   = (r_max_particles > 7'(MAX_POOL)) ? 7'(MAX_POOL) : r_max_particles;
        limit  = CNT_W'(lim7);
        room   = limit - r_count;
        sum33  = {1'b0, r_acc} + {1'b0, r_prod[31:0]};
        sum32  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
        whole  = sum32[31:24];
        nsp    = (whole < 8'(room)) ? CNT_W'(whole) : room;
        a0     = r_alpha_setup[7:0];
        a1     = r_alpha_setup[15:8];
        aneg   = a0 > a1;
        adiff  = aneg ? (a0 - a1) : (a1 - a0);
        life   = {r_max_age, 8'h00};
        age_sum = {1'b0, mem_rdata.age} + {9'b0, r_dt};
        asum   = {1'b0, a0} + {1'b0, div_quo[7:0]};
        if (r_max_age == 16'h0000) begin
            alpha_v = a0;
        end else if (!aneg) begin
            alpha_v = (div_quo > 32'd255 || asum > 9'd255) ? 8'hFF : asum[7:0];
        end else begin
            alpha_v = (div_quo > {24'b0, a0}) ? 8'h00 : (a0 - div_quo[7:0]);
        end
        keep_it = r_age_n < life;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DVX: begin
                mul_a = 33'(signed'(r_accel_xy[15:0]));
                mul_b = {2'b00, r_dt};
            end
            ST_DVY: begin
                mul_a = 33'(signed'(r_accel_xy[31:16]));
                mul_b = {2'b00, r_dt};
            end
            ST_EMIT: begin
                mul_a = {17'b0, r_emit_rate};
                mul_b = {2'b00, r_dt};
            end
            ST_SP_A: begin
                mul_a = {17'b0, r_direction[31:16]};
                mul_b = 18'(rnd);
            end
            ST_SP_B: begin
                mul_a = 33'(signed'(r_power_setup[31:16]));
                mul_b = 18'(rnd);
            end
            ST_SP_D: begin
                mul_a = 33'(r_power);
                mul_b = 18'(r_cs);
            end
            ST_SP_E: begin
                mul_a = 33'(r_power);
                mul_b = 18'(r_sn);
            end
            ST_UP_LD: begin
                mul_a = {9'b0, mem_rdata.age};
                mul_b = {10'b0, adiff};
            end
            ST_UP_MA: begin
                mul_a = 33'(r_vx_n);
                mul_b = {2'b00, r_dt};
            end
            ST_UP_MX: begin
                mul_a = 33'(r_vy_n);
                mul_b = {2'b00, r_dt};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_tick_valid) n_state = ST_DVX;
            ST_DVX:    n_state = ST_DVY;
            ST_DVY:    n_state = ST_EMIT;
            ST_EMIT:   n_state = ST_ACC;
            ST_ACC:    n_state = (r_count < limit && nsp != '0) ? ST_SP_A : ST_UP_RD;
            ST_SP_A:   n_state = ST_SP_B;
            ST_SP_B:   n_state = ST_SP_C;
            ST_SP_C:   n_state = ST_SP_D;
            ST_SP_D:   n_state = ST_SP_E;
            ST_SP_E:   n_state = ST_SP_F;
            ST_SP_F:   n_state = (r_nspawn == CNT_W'(1)) ? ST_UP_RD : ST_SP_A;
            ST_UP_RD:  n_state = (r_i == r_count) ? ST_OUT_RD : ST_UP_LD;
            ST_UP_LD:  n_state = ST_UP_MA;
            ST_UP_MA:  n_state = ST_UP_MX;
            ST_UP_MX:  n_state = ST_UP_MY;
            ST_UP_MY:  n_state = ST_UP_WB;
            ST_UP_WB:  if (!div_busy) n_state = ST_UP_RD;
            ST_OUT_RD: n_state = (r_count == '0) ? ST_OUT_HOLD : ST_OUT_LD;
            ST_OUT_LD: n_state = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (i_res_ready) begin
                    n_state = r_out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_tick_ready = (r_state == ST_IDLE);
        o_res_valid  = (r_state == ST_OUT_HOLD);
        div_start    = (r_state == ST_UP_MA);
        mem_re       = 1'b0;
        mem_raddr    = r_i[IDX_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = r_keep[IDX_W-1:0];
        mem_wdata    = '{alpha: alpha_v, age: r_age_n, vel_x: r_vx_n, vel_y: r_vy_n,
                         pos_x: r_px, pos_y: r_py};
        unique case (r_state)
            ST_SP_F: begin
                mem_we    = 1'b1;
                mem_waddr = r_count[IDX_W-1:0];
                mem_wdata = '{alpha: 8'h00, age: 24'h0, vel_x: r_vx,
                              vel_y: r_prod[37:6], pos_x: 32'sh0, pos_y: 32'sh0};
            end
            ST_UP_RD: begin
                mem_re = (r_i != r_count);
            end
            ST_UP_WB: begin
                mem_we = !div_busy && keep_it;
            end
            ST_OUT_RD: begin
                mem_re    = (r_count != '0);
                mem_raddr = r_j[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_max_particles <= 7'd1;
            r_emit_rate     <= 16'd256;
            r_max_age       <= 16'd256;
            r_accel_xy      <= '0;
            r_direction     <= '0;
            r_power_setup   <= '0;
            r_alpha_setup   <= 16'd255;
            r_lfsr          <= LFSR_RESET;
            r_acc           <= '0;
            r_count         <= '0;
            r_nspawn        <= '0;
            r_i             <= '0;
            r_keep          <= '0;
            r_j             <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_PARTICLES: r_max_particles <= i_cfg_wdata[6:0];
                    CFG_EMIT_RATE:     r_emit_rate     <= i_cfg_wdata[15:0];
                    CFG_MAX_AGE:       r_max_age       <= i_cfg_wdata[15:0];
                    CFG_ACCEL_XY:      r_accel_xy      <= i_cfg_wdata;
                    CFG_DIRECTION:     r_direction     <= i_cfg_wdata;
                    CFG_POWER:         r_power_setup   <= i_cfg_wdata;
                    CFG_ALPHA:         r_alpha_setup   <= i_cfg_wdata[15:0];
                    CFG_RANDOM_SEED: begin
                        r_lfsr <= (i_cfg_wdata[15:0] == 16'h0000) ? 16'h0001
                                                                  : i_cfg_wdata[15:0];
                    end
                    default: ;
                endcase
            end
            case (r_state)
                ST_ACC: begin
                    r_i    <= '0;
                    r_keep <= '0;
                    if (r_count < limit) begin
                        r_acc    <= sum32 - ({{(32 - CNT_W){1'b0}}, nsp} << 24);
                        r_nspawn <= nsp;
                    end else begin
                        r_acc    <= '0;
                        r_nspawn <= '0;
                    end
                end
                ST_SP_A, ST_SP_B: r_lfsr <= lfsr_n;
                ST_SP_F: begin
                    r_count  <= r_count + 1'b1;
                    r_nspawn <= r_nspawn - 1'b1;
                end
                ST_UP_RD: begin
                    if (r_i == r_count) begin
                        r_count <= r_keep;
                        r_j     <= '0;
                    end
                end
                ST_UP_WB: begin
                    if (!div_busy) begin
                        r_i <= r_i + 1'b1;
                        if (keep_it) begin
                            r_keep <= r_keep + 1'b1;
                        end
                    end
                end
                ST_OUT_HOLD: begin
                    if (i_res_ready) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_dt <= i_tick_time;
            ST_DVY:  r_dvx <= r_prod[39:8];
            ST_EMIT: r_dvy <= r_prod[39:8];
            ST_SP_B: r_angle <= r_direction[15:0] + r_prod[31:16];
            ST_SP_C: begin
                r_power <= 17'(signed'(r_power_setup[15:0])) + r_prod[32:16];
                r_sn    <= trig_val(r_angle[15 -: TRIG_BITS], 1'b0);
                r_cs    <= trig_val(r_angle[15 -: TRIG_BITS], 1'b1);
            end
            ST_SP_E: r_vx <= r_prod[37:6];
            ST_UP_LD: begin
                r_age_n <= age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
                r_vx_n  <= sat32(34'(mem_rdata.vel_x) + 34'(r_dvx));
                r_vy_n  <= sat32(34'(mem_rdata.vel_y) + 34'(r_dvy));
                r_px    <= mem_rdata.pos_x;
                r_py    <= mem_rdata.pos_y;
            end
            ST_UP_MX: r_px <= sat32(34'(r_px) + 34'(signed'(r_prod[48:16])));
            ST_UP_MY: r_py <= sat32(34'(r_py) + 34'(signed'(r_prod[48:16])));
            ST_OUT_RD: begin
                r_out_px    <= '0;
                r_out_py    <= '0;
                r_out_alpha <= '0;
                r_out_empty <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_live  <= '0;
            end
            ST_OUT_LD: begin
                r_out_px    <= mem_rdata.pos_x;
                r_out_py    <= mem_rdata.pos_y;
                r_out_alpha <= mem_rdata.alpha;
                r_out_empty <= 1'b0;
                r_out_last  <= (r_j + 1'b1 == r_count);
                r_out_live  <= 7'(r_count);
            end
            default: ;
        endcase
    end

    assign o_pos_x      = r_out_px;
    assign o_pos_y      = r_out_py;
    assign o_alpha      = r_out_alpha;
    assign o_slot_empty = r_out_empty;
    assign o_last_one   = r_out_last;
    assign o_live_count = r_out_live;

endmodule

// ===== tb/tb_particle_emitter_update.sv =====
// Testbench for particle_emitter_update: directed table plus random ticks, each
// result word checked against a built-in model of the particle pool.
// Depends on pe_pkg and the particle_emitter_update RTL.
module tb_particle_emitter_update;
    timeunit 1ns;
    timeprecision 1ps;
    import pe_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 700;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [7:0]         alpha;
        logic               empty;
        logic               last;
        logic [6:0]         count;
    } t_particle_word;

    typedef enum int {ROW_CFG, ROW_TICK, ROW_HOLD} t_row_kind;

    typedef struct {
        t_row_kind      kind;
        t_cfg_idx       reg_idx;
        logic [31:0]    data;
        logic           has_exp;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    t_cfg_idx    i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_tick_valid;
    logic        o_tick_ready;
    logic [15:0] i_tick_time;
    logic        o_res_valid;
    logic        i_res_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic [7:0]  o_alpha;
    logic        o_slot_empty;
    logic        o_last_one;
    logic [6:0]  o_live_count;

    particle_emitter_update DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_tick_valid(i_tick_valid), .o_tick_ready(o_tick_ready), .i_tick_time(i_tick_time),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_alpha(o_alpha),
        .o_slot_empty(o_slot_empty), .o_last_one(o_last_one), .o_live_count(o_live_count)
    );

    // model state
    logic [6:0]  m_max_particles;
    logic [15:0] m_emit_rate, m_max_age, m_alpha_setup;
    logic [31:0] m_accel, m_direction, m_power;
    logic [23:0] m_age   [MAX_POOL];
    logic signed [31:0] m_vel_x [MAX_POOL];
    logic signed [31:0] m_vel_y [MAX_POOL];
    logic signed [31:0] m_pos_x [MAX_POOL];
    logic signed [31:0] m_pos_y [MAX_POOL];
    int          m_pool;
    logic [31:0] m_accum;
    logic [15:0] m_lfsr;

    t_particle_word pending_words[$];
    t_particle_word tick_first;
    int  tick_words;
    int  errors = 0;
    int  n_ticks = 0;
    int  n_words = 0;
    int  n_spawned = 0;
    int  cycles = 0;
    bit  quiet = 0;
    bit  hold_req = 0;

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sine_q14(int phase);
        longint u, v, w, t, s;
        int q, rem;
        q   = phase / 256;
        rem = phase % 256;
        u   = (q & 1) ? (256 - rem) : rem;
        v   = (u <<< 30) / 256;
        w   = (v * v) >>> 30;
        t   = 64'sd172272;
        t   = 64'sd5026994 - ((t * w) >>> 30);
        t   = 64'sd85569306 - ((t * w) >>> 30);
        t   = 64'sd693598668 - ((t * w) >>> 30);
        t   = 64'sd1686629713 - ((t * w) >>> 30);
        s   = (t * v) >>> 30;
        s   = (s + 32768) >>> 16;
        if (s > 16384) s = 16384;
        return (q & 2) ? -s : s;
    endfunction

    function automatic longint lfsr_step();
        m_lfsr = (m_lfsr >> 1) ^ (m_lfsr[0] ? 16'hB400 : 16'h0000);
        return longint'(m_lfsr) - 32768;
    endfunction

    function automatic void spawn_particle();
        longint r1, r2, off, pwr, sn, cs;
        logic [15:0] angle;
        int idx;
        r1    = lfsr_step();
        r2    = lfsr_step();
        off   = (longint'(m_direction[31:16]) * r1) >>> 16;
        angle = 16'(longint'(m_direction[15:0]) + off);
        pwr   = sx16(m_power[15:0]) + ((sx16(m_power[31:16]) * r2) >>> 16);
        idx   = angle[15:8];
        sn    = sine_q14(4 * idx);
        cs    = sine_q14(4 * idx + 256);
        if (m_pool >= MAX_POOL) return;
        m_vel_x[m_pool] = clip32((pwr * cs) >>> 6);
        m_vel_y[m_pool] = clip32((pwr * sn) >>> 6);
        m_pos_x[m_pool] = 0;
        m_pos_y[m_pool] = 0;
        m_age[m_pool]   = 0;
        m_pool++;
        n_spawned++;
    endfunction

    function automatic void model_write(t_cfg_idx r, logic [31:0] d);
        case (r)
            CFG_MAX_PARTICLES: m_max_particles = d[6:0];
            CFG_EMIT_RATE:     m_emit_rate = d[15:0];
            CFG_MAX_AGE:       m_max_age = d[15:0];
            CFG_ACCEL_XY:      m_accel = d;
            CFG_DIRECTION:     m_direction = d;
            CFG_POWER:         m_power = d;
            CFG_ALPHA:         m_alpha_setup = d[15:0];
            CFG_RANDOM_SEED: begin
                m_lfsr = (d[15:0] != 0) ? d[15:0] : 16'd1;
            end
            default: ;
        endcase
    endfunction

    // run one tick through the model and queue the words it produces
    function automatic void predict_tick(logic [15:0] dt);
        int limit, keep, nsp, room;
        longint dvx, dvy, a0, diff, life, sum, a, vx, vy, age, dtl;
        t_particle_word w;
        t_particle_word words[$];
        dtl   = longint'(dt);
        limit = (m_max_particles > MAX_POOL) ? MAX_POOL : m_max_particles;
        dvx   = longint'(clip32((sx16(m_accel[15:0]) * dtl) >>> 8));
        dvy   = longint'(clip32((sx16(m_accel[31:16]) * dtl) >>> 8));
        a0    = m_alpha_setup[7:0];
        diff  = longint'(m_alpha_setup[15:8]) - a0;
        life  = longint'(m_max_age) << 8;
        keep  = 0;
        if (m_lfsr == 0) m_lfsr = 1;
        if (m_pool < limit) begin
            sum = longint'(m_accum) + dtl * longint'(m_emit_rate);
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
            room = limit - m_pool;
            nsp  = ((sum >> 24) < room) ? int'(sum >> 24) : room;
            m_accum = 32'(sum - (longint'(nsp) << 24));
            for (int k = 0; k < nsp; k++) spawn_particle();
        end else begin
            m_accum = 0;
        end
        for (int i = 0; i < m_pool; i++) begin
            age = m_age[i];
            a   = a0;
            if (life != 0) a = a + (diff * age) / life;
            if (a < 0) a = 0;
            if (a > 255) a = 255;
            age = age + dtl;
            if (age > 64'hFF_FFFF) age = 64'hFF_FFFF;
            vx = clip32(longint'(m_vel_x[i]) + dvx);
            vy = clip32(longint'(m_vel_y[i]) + dvy);
            if (age >= life) continue;
            m_age[keep]   = age[23:0];
            m_vel_x[keep] = vx[31:0];
            m_vel_y[keep] = vy[31:0];
            m_pos_x[keep] = clip32(longint'(m_pos_x[i]) + ((vx * dtl) >>> 16));
            m_pos_y[keep] = clip32(longint'(m_pos_y[i]) + ((vy * dtl) >>> 16));
            w.pos_x = m_pos_x[keep];
            w.pos_y = m_pos_y[keep];
            w.alpha = a[7:0];
            w.empty = 0;
            w.last  = 0;
            w.count = 0;
            words.insert(words.size(), w);
            keep++;
        end
        m_pool = keep;
        if (keep == 0) begin
            w = '{0, 0, 0, 1, 1, 0};
            words.insert(words.size(), w);
        end else begin
            foreach (words[i]) words[i].count = 7'(keep);
            words[keep - 1].last = 1;
        end
        tick_first = words[0];
        tick_words = words.size();
        foreach (words[i]) pending_words.insert(pending_words.size(), words[i]);
        n_ticks++;
    endfunction

    function automatic void report(string what, t_particle_word e, t_particle_word g);
        errors++;
        if (errors <= 10)
            $display({"[%0t] %s: exp x=%0d y=%0d a=%0d e=%0b l=%0b n=%0d",
                      " got x=%0d y=%0d a=%0d e=%0b l=%0b n=%0d"},
                     $realtime, what, e.pos_x, e.pos_y, e.alpha, e.empty, e.last, e.count,
                     g.pos_x, g.pos_y, g.alpha, g.empty, g.last, g.count);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        t_particle_word e, g;
        i_res_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                stall = HOLD_CYCLES;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                i_res_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_res_ready <= 1;
            do @(posedge i_clk); while (!o_res_valid);
            g = '{o_pos_x, o_pos_y, o_alpha, o_slot_empty, o_last_one, o_live_count};
            n_words++;
            if (pending_words.size() == 0) begin
                report("unexpected word", g, g);
            end else begin
                e = pending_words.pop_front();
                if (e !== g) report("mismatch", e, g);
            end
        end
    end

    task automatic wait_idle();
        i_tick_valid <= 0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx r, logic [31:0] d);
        i_cfg_wr_en <= 1;
        i_cfg_index <= r;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        model_write(r, d);
    endtask

    task automatic send_tick(logic [15:0] dt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_tick_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_tick_valid <= 1;
        i_tick_time  <= dt;
        do @(posedge i_clk); while (!o_tick_ready);
        predict_tick(dt);
    endtask

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] rnd);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return rnd;
        endcase
    endfunction

    t_dir_row dir_tab [32] = '{
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'hFFFF, 1},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0000, 1},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0001, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0064, 0},
        '{ROW_CFG,  CFG_MAX_PARTICLES, 32'd64, 0},
        '{ROW_CFG,  CFG_EMIT_RATE,     32'hFFFF, 0},
        '{ROW_CFG,  CFG_MAX_AGE,       32'hFFFF, 0},
        '{ROW_CFG,  CFG_ACCEL_XY,      32'h8000_7FFF, 0},
        '{ROW_CFG,  CFG_DIRECTION,     32'hFFFF_0000, 0},
        '{ROW_CFG,  CFG_POWER,         32'h8000_7FFF, 0},
        '{ROW_CFG,  CFG_ALPHA,         32'h0000_00FF, 0},
        '{ROW_CFG,  CFG_RANDOM_SEED,   32'h0000_0000, 0},
        '{ROW_HOLD, CFG_MAX_PARTICLES, 32'h0, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'hFFFF, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'hFFFF, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0000, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h8000, 0},
        '{ROW_CFG,  CFG_MAX_AGE,       32'h0000, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0001, 1},
        '{ROW_CFG,  CFG_MAX_PARTICLES, 32'd127, 0},
        '{ROW_CFG,  CFG_ALPHA,         32'h0000_FF00, 0},
        '{ROW_CFG,  CFG_MAX_AGE,       32'h0001, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'h0001, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'hFFFF, 1},
        '{ROW_CFG,  CFG_POWER,         32'h7FFF_8000, 0},
        '{ROW_CFG,  CFG_DIRECTION,     32'h0000_FFFF, 0},
        '{ROW_CFG,  CFG_ACCEL_XY,      32'h7FFF_8000, 0},
        '{ROW_CFG,  CFG_MAX_AGE,       32'h0400, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'd300, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'd300, 0},
        '{ROW_CFG,  CFG_MAX_PARTICLES, 32'd0, 0},
        '{ROW_TICK, CFG_MAX_PARTICLES, 32'd500, 0}
    };

    initial begin
        t_particle_word lone_empty;
        bit prev_cfg;
        lone_empty   = '{0, 0, 0, 1, 1, 0};
        i_rst_n      = 0;
        i_cfg_wr_en  = 0;
        i_cfg_index  = CFG_MAX_PARTICLES;
        i_cfg_wdata  = 0;
        i_tick_valid = 0;
        i_tick_time  = 0;
        m_max_particles = 1;
        m_emit_rate = 256;
        m_max_age = 256;
        m_accel = 0;
        m_direction = 0;
        m_power = 0;
        m_alpha_setup = 255;
        m_lfsr = 16'hACE1;
        m_pool = 0;
        m_accum = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        prev_cfg = 0;
        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                if (!prev_cfg) wait_idle();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].data);
                prev_cfg = 1;
            end else begin
                if (prev_cfg) i_cfg_wr_en <= 0;
                prev_cfg = 0;
                if (dir_tab[r].kind == ROW_HOLD) begin
                    hold_req = 1;
                end else begin
                    send_tick(dir_tab[r].data[15:0]);
                    if (dir_tab[r].has_exp && (tick_words != 1 || tick_first !== lone_empty))
                        report("directed row", lone_empty, tick_first);
                end
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            quiet = (ph % 3 == 1);
            write_reg(CFG_MAX_PARTICLES, (ph == 7) ? 32'd127 :
                      pick(0, 64, $urandom_range(1, 8)));
            write_reg(CFG_EMIT_RATE, pick(0, 32'hFFFF, $urandom_range(0, 32'hFFFF)));
            write_reg(CFG_MAX_AGE, pick(0, 32'hFFFF, $urandom_range(1, 32'h0800)));
            write_reg(CFG_ACCEL_XY, $urandom);
            write_reg(CFG_DIRECTION, $urandom);
            write_reg(CFG_POWER, $urandom);
            write_reg(CFG_ALPHA, $urandom_range(0, 32'hFFFF));
            write_reg(CFG_RANDOM_SEED, pick(0, 32'hFFFF, $urandom_range(1, 32'hFFFF)));
            i_cfg_wr_en <= 0;
            for (int k = 0; k < 19; k++)
                send_tick(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                                      : 16'($urandom_range(0, 32'hFFFF)));
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("ran %0d ticks, %0d particles spawned, %0d words checked, %0d errors",
                 n_ticks, n_spawned, n_words, errors);
        if (errors == 0 && pending_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
